// ===== src/ddp_pkg.sv =====
// ddp_pkg: shared constants, codes and byte-class helpers for the doctype parser
// used by ddp_classify and doctype_declaration_parser; no dependencies
package ddp_pkg;

  // result kind tags
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_SUBSET = 2'd2;
  localparam logic [1:0] KIND_LIT    = 2'd3;

  // dense error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_KEY_END     = 4'd1;
  localparam logic [3:0] ERR_KEY_BAD     = 4'd2;
  localparam logic [3:0] ERR_KEY_SPACE   = 4'd3;
  localparam logic [3:0] ERR_NAME_START  = 4'd4;
  localparam logic [3:0] ERR_NAME_CHAR   = 4'd5;
  localparam logic [3:0] ERR_NAME_SPACE  = 4'd6;
  localparam logic [3:0] ERR_SUBSET_END  = 4'd7;
  localparam logic [3:0] ERR_EXT_ID      = 4'd8;
  localparam logic [3:0] ERR_ID_SPACE    = 4'd9;
  localparam logic [3:0] ERR_OPEN_QUOTE  = 4'd10;
  localparam logic [3:0] ERR_CLOSE_QUOTE = 4'd11;
  localparam logic [3:0] ERR_LIT_END     = 4'd12;

  // delimiter bytes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SYS0   = 8'h53;

  // last keyword positions
  localparam logic [2:0] KEY_LAST_POS = 3'd6;
  localparam logic [2:0] SYS_LAST_POS = 3'd5;

  // classification of one byte, handed to the state machine
  typedef struct packed {
    logic is_zero;
    logic is_space;
    logic is_quote;
    logic is_gt;
    logic is_lbrack;
    logic is_rbrack;
    logic is_name_start;
    logic is_name_char;
    logic key_match;
    logic sys_match;
    logic sys0_match;
  } byte_class_t;

  // keyword DOCTYPE, position taken modulo 7
  function automatic logic [7:0] doctype_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h44;  // D
      3'd1:    ch = 8'h4F;  // O
      3'd2:    ch = 8'h43;  // C
      3'd3:    ch = 8'h54;  // T
      3'd4:    ch = 8'h59;  // Y
      3'd5:    ch = 8'h50;  // P
      3'd6:    ch = 8'h45;  // E
      default: ch = 8'h44;  // wraps to D
    endcase
    return ch;
  endfunction

  // keyword SYSTEM, position taken modulo 6
  function automatic logic [7:0] system_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h53;  // S
      3'd1:    ch = 8'h59;  // Y
      3'd2:    ch = 8'h53;  // S
      3'd3:    ch = 8'h54;  // T
      3'd4:    ch = 8'h45;  // E
      3'd5:    ch = 8'h4D;  // M
      3'd6:    ch = 8'h53;  // wraps to S
      default: ch = 8'h59;  // wraps to Y
    endcase
    return ch;
  endfunction

endpackage

// ===== src/ddp_classify.sv =====
// ddp_classify: byte class decode and keyword compare for the doctype parser
// depends on ddp_pkg
module ddp_classify (
  input  logic [7:0]           in_byte,
  input  logic [2:0]           position,
  output ddp_pkg::byte_class_t cls
);
  import ddp_pkg::*;

  logic is_upper;
  logic is_lower;
  logic is_digit;
  logic is_letter;

  // ascii letter and digit ranges
  assign is_upper  = (in_byte >= 8'h41) && (in_byte <= 8'h5A);
  assign is_lower  = (in_byte >= 8'h61) && (in_byte <= 8'h7A);
  assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign is_letter = is_upper || is_lower;

  // delimiter and class flags
  always_comb begin
    cls.is_zero       = (in_byte == CH_NUL);
    cls.is_space      = (in_byte == CH_SPACE);
    cls.is_quote      = (in_byte == CH_QUOTE);
    cls.is_gt         = (in_byte == CH_GT);
    cls.is_lbrack     = (in_byte == CH_LBRACK);
    cls.is_rbrack     = (in_byte == CH_RBRACK);
    cls.is_name_start = is_letter || (in_byte == CH_US);
    cls.is_name_char  = is_letter || is_digit || (in_byte == CH_US) ||
                        (in_byte == 8'h2D) || (in_byte == 8'h2E) ||
                        (in_byte == 8'h3A);
    cls.key_match     = (in_byte == doctype_char(position));
    cls.sys_match     = (in_byte == system_char(position));
    cls.sys0_match    = (in_byte == CH_SYS0);
  end

endmodule

// ===== src/doctype_declaration_parser.sv =====
// doctype_declaration_parser: byte-serial DOCTYPE declaration recognizer
// pipeline: input register, then result register, between input accept and result valid
// throughput: 1 item per cycle while the result register is not held by out_ready low
// reset: synchronous active-high rst clears phase to idle, position and mismatch flag,
// and empties both the input and result registers
// depends on ddp_pkg and ddp_classify
module doctype_declaration_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_req,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       done_res,
  output logic [3:0] error_code
);
  import ddp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_KEY, PH_KSPACE, PH_NSTART, PH_NAME, PH_BRANCH, PH_SUBSET,
    PH_SUBEND, PH_EXTID, PH_IDSP, PH_QUOTE, PH_LIT, PH_LITEND
  } phase_t;

  // input register
  logic       in_q_valid;
  logic       start_q;
  logic [7:0] byte_q;

  // parser state
  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] position;
  logic [2:0] position_next;
  logic       id_mismatch;
  logic       id_mismatch_next;

  // step results
  phase_t      phase_eff;
  logic [2:0]  pos_eff;
  logic        mism_eff;
  logic [7:0]  res_byte;
  logic [1:0]  res_kind;
  logic        res_done;
  logic [3:0]  res_err;
  byte_class_t cls;
  logic        advance;

  // handshake: input register moves on when the result register can take it
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;

  // start abandons any declaration in progress
  assign phase_eff = start_q ? PH_KEY : phase;
  assign pos_eff   = start_q ? 3'd0 : position;
  assign mism_eff  = start_q ? 1'b0 : id_mismatch;

  ddp_classify u_classify (
    .in_byte  (byte_q),
    .position (pos_eff),
    .cls      (cls)
  );

  // one parser step
  always_comb begin
    phase_next       = phase_eff;
    position_next    = pos_eff;
    id_mismatch_next = mism_eff;
    res_byte         = CH_NUL;
    res_kind         = KIND_NONE;
    res_done         = 1'b0;
    res_err          = ERR_NONE;
    unique case (phase_eff)
      PH_KEY: begin
        if (cls.is_zero) begin
          res_err = ERR_KEY_END;
        end else if (!cls.key_match) begin
          res_err = ERR_KEY_BAD;
        end else if (pos_eff >= KEY_LAST_POS) begin
          phase_next = PH_KSPACE;
        end else begin
          position_next = pos_eff + 3'd1;
        end
      end
      PH_KSPACE: begin
        if (!cls.is_space) res_err = ERR_KEY_SPACE;
        else phase_next = PH_NSTART;
      end
      PH_NSTART: begin
        if (!cls.is_name_start) begin
          res_err = ERR_NAME_START;
        end else begin
          res_byte   = byte_q;
          res_kind   = KIND_NAME;
          phase_next = PH_NAME;
        end
      end
      PH_NAME: begin
        if (cls.is_gt) begin
          res_done = 1'b1;
        end else if (cls.is_space) begin
          phase_next = PH_BRANCH;
        end else if (cls.is_zero) begin
          res_err = ERR_NAME_SPACE;
        end else if (!cls.is_name_char) begin
          res_err = ERR_NAME_CHAR;
        end else begin
          res_byte = byte_q;
          res_kind = KIND_NAME;
        end
      end
      PH_BRANCH: begin
        if (cls.is_lbrack) begin
          phase_next = PH_SUBSET;
        end else begin
          id_mismatch_next = !cls.sys0_match;
          position_next    = 3'd1;
          phase_next       = PH_EXTID;
        end
      end
      PH_SUBSET: begin
        if (cls.is_rbrack) begin
          phase_next = PH_SUBEND;
        end else if (cls.is_zero) begin
          res_err = ERR_SUBSET_END;
        end else begin
          res_byte = byte_q;
          res_kind = KIND_SUBSET;
        end
      end
      PH_SUBEND: begin
        if (cls.is_gt) res_done = 1'b1;
        else res_err = ERR_SUBSET_END;
      end
      PH_EXTID: begin
        // mismatch is collected and only reported on the last id byte
        id_mismatch_next = mism_eff || !cls.sys_match;
        if (pos_eff >= SYS_LAST_POS) begin
          if (id_mismatch_next) res_err = ERR_EXT_ID;
          else phase_next = PH_IDSP;
        end else begin
          position_next = pos_eff + 3'd1;
        end
      end
      PH_IDSP: begin
        if (!cls.is_space) res_err = ERR_ID_SPACE;
        else phase_next = PH_QUOTE;
      end
      PH_QUOTE: begin
        if (!cls.is_quote) res_err = ERR_OPEN_QUOTE;
        else phase_next = PH_LIT;
      end
      PH_LIT: begin
        if (cls.is_quote) begin
          phase_next = PH_LITEND;
        end else if (cls.is_zero) begin
          res_err = ERR_CLOSE_QUOTE;
        end else begin
          res_byte = byte_q;
          res_kind = KIND_LIT;
        end
      end
      PH_LITEND: begin
        if (cls.is_gt) res_done = 1'b1;
        else res_err = ERR_LIT_END;
      end
      default: begin
        // idle without start: nothing happens
      end
    endcase
    // done or error returns to idle
    if (res_done || (res_err != ERR_NONE)) begin
      phase_next       = PH_IDLE;
      position_next    = 3'd0;
      id_mismatch_next = 1'b0;
    end
  end

  // input register, parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_IDLE;
      position    <= 3'd0;
      id_mismatch <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        position    <= position_next;
        id_mismatch <= id_mismatch_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      start_q <= start_req;
      byte_q  <= in_byte;
    end
    if (advance) begin
      out_byte   <= res_byte;
      out_kind   <= res_kind;
      done_res   <= res_done;
      error_code <= res_err;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && (error_code != ERR_NONE)))
    else $error("done and error raised together");

  a_kind_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_NONE)) |-> (!done_res && (error_code == ERR_NONE)))
    else $error("captured byte alongside done or error");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_NONE)) |-> (out_byte == CH_NUL))
    else $error("out_byte not zero without a kind");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> ((position == 3'd0) && !id_mismatch))
    else $error("idle with stale position or mismatch");
`endif

endmodule

// ===== tb/tb_doctype_declaration_parser.sv =====
// tb_doctype_declaration_parser: self-checking bench for the doctype declaration parser
// byte items are driven through valid/ready and each result is checked against a local decoder
// depends on ddp_pkg and the doctype_declaration_parser rtl
module tb_doctype_declaration_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ddp_pkg::*;

  localparam int ITEM_TARGET   = 1600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int IDLE_PERCENT  = 35;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 250;
  localparam int CALM_FROM     = 900;
  localparam int CALM_TO       = 1200;

  localparam logic [7:0] DOCTYPE_KW [0:6] = '{"D", "O", "C", "T", "Y", "P", "E"};
  localparam logic [7:0] SYSTEM_KW  [0:5] = '{"S", "Y", "S", "T", "E", "M"};
  localparam string NAME_POOL =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_-.:";
  localparam string LETTER_POOL =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";

  // decoder phases
  typedef enum logic [3:0] {
    S_IDLE, S_KEYWORD, S_KEY_SPACE, S_NAME_START, S_NAME, S_AFTER_NAME,
    S_SUBSET, S_SUBSET_CLOSE, S_EXT_ID, S_ID_SPACE, S_OPEN_QUOTE, S_LITERAL,
    S_LIT_CLOSE
  } decode_phase_e;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       done;
    logic [3:0] err;
  } parse_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       start_req = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       done_res;
  logic [3:0] error_code;

  byte_item_t    pending_bytes[$];
  parse_result_t expected_results[$];

  // local decoder state
  decode_phase_e dec_phase = S_IDLE;
  logic [2:0]    dec_pos = '0;
  logic          dec_sys_bad = 1'b0;

  logic  in_taken = 1'b0;
  int    bytes_sent = 0;
  int    results_seen = 0;
  int    decls_done = 0;
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    hold_left = 0;
  bit    hold_used = 1'b0;
  logic [15:0] errors_seen = '0;
  logic  calm;

  doctype_declaration_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .done_res  (done_res),
    .error_code(error_code)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // no random idling on either side in this window
  assign calm = (bytes_sent >= CALM_FROM) && (bytes_sent < CALM_TO);

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_name_byte(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == CH_US || c == "-" ||
           c == "." || c == ":";
  endfunction

  // advance the local decoder by one byte and return the result it gives
  function automatic parse_result_t decode_byte(input logic start, input logic [7:0] c);
    parse_result_t r;
    r = '0;
    if (start) begin
      dec_phase   = S_KEYWORD;
      dec_pos     = '0;
      dec_sys_bad = 1'b0;
    end
    case (dec_phase)
      S_KEYWORD: begin
        if (c == CH_NUL) r.err = ERR_KEY_END;
        else if (c != DOCTYPE_KW[dec_pos % 3'd7]) r.err = ERR_KEY_BAD;
        else if (dec_pos >= KEY_LAST_POS) dec_phase = S_KEY_SPACE;
        else dec_pos = dec_pos + 3'd1;
      end
      S_KEY_SPACE: begin
        if (c != CH_SPACE) r.err = ERR_KEY_SPACE;
        else dec_phase = S_NAME_START;
      end
      S_NAME_START: begin
        if (!is_letter(c) && c != CH_US) begin
          r.err = ERR_NAME_START;
        end else begin
          r.data    = c;
          r.kind    = KIND_NAME;
          dec_phase = S_NAME;
        end
      end
      S_NAME: begin
        if (c == CH_GT) r.done = 1'b1;
        else if (c == CH_SPACE) dec_phase = S_AFTER_NAME;
        else if (c == CH_NUL) r.err = ERR_NAME_SPACE;
        else if (!is_name_byte(c)) r.err = ERR_NAME_CHAR;
        else begin
          r.data = c;
          r.kind = KIND_NAME;
        end
      end
      S_AFTER_NAME: begin
        if (c == CH_LBRACK) begin
          dec_phase = S_SUBSET;
        end else begin
          // first SYSTEM byte is taken here, the verdict comes on the last one
          dec_sys_bad = (c != SYSTEM_KW[0]);
          dec_pos     = 3'd1;
          dec_phase   = S_EXT_ID;
        end
      end
      S_SUBSET: begin
        if (c == CH_RBRACK) dec_phase = S_SUBSET_CLOSE;
        else if (c == CH_NUL) r.err = ERR_SUBSET_END;
        else begin
          r.data = c;
          r.kind = KIND_SUBSET;
        end
      end
      S_SUBSET_CLOSE: begin
        if (c == CH_GT) r.done = 1'b1;
        else r.err = ERR_SUBSET_END;
      end
      S_EXT_ID: begin
        if (c != SYSTEM_KW[dec_pos % 3'd6]) dec_sys_bad = 1'b1;
        if (dec_pos >= SYS_LAST_POS) begin
          if (dec_sys_bad) r.err = ERR_EXT_ID;
          else dec_phase = S_ID_SPACE;
        end else begin
          dec_pos = dec_pos + 3'd1;
        end
      end
      S_ID_SPACE: begin
        if (c != CH_SPACE) r.err = ERR_ID_SPACE;
        else dec_phase = S_OPEN_QUOTE;
      end
      S_OPEN_QUOTE: begin
        if (c != CH_QUOTE) r.err = ERR_OPEN_QUOTE;
        else dec_phase = S_LITERAL;
      end
      S_LITERAL: begin
        if (c == CH_QUOTE) dec_phase = S_LIT_CLOSE;
        else if (c == CH_NUL) r.err = ERR_CLOSE_QUOTE;
        else begin
          r.data = c;
          r.kind = KIND_LIT;
        end
      end
      S_LIT_CLOSE: begin
        if (c == CH_GT) r.done = 1'b1;
        else r.err = ERR_LIT_END;
      end
      default: ;
    endcase
    if (r.done || r.err != ERR_NONE) begin
      dec_phase   = S_IDLE;
      dec_pos     = '0;
      dec_sys_bad = 1'b0;
    end
    return r;
  endfunction

  task automatic add_byte(input logic start, input logic [7:0] c);
    pending_bytes.push_back('{start: start, data: c});
  endtask

  function automatic logic [7:0] pick_from(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // any byte but end of input and the given terminator
  function automatic logic [7:0] pick_content(input logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == stop);
    return b;
  endfunction

  function automatic int pick_length();
    // mostly short fields, now and then a long one
    if ($urandom_range(0, 19) == 0) return $urandom_range(13, 40);
    return $urandom_range(0, 12);
  endfunction

  // one declaration of random shape and content, sometimes damaged
  task automatic add_declaration();
    logic [7:0] body[$];
    int n;
    int at;
    int damage;
    for (int i = 0; i < 7; i++) body.push_back(DOCTYPE_KW[i]);
    body.push_back(CH_SPACE);
    body.push_back(pick_from(LETTER_POOL));
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) body.push_back(pick_from(NAME_POOL));
    case ($urandom_range(0, 2))
      0: body.push_back(CH_GT);
      1: begin
        body.push_back(CH_SPACE);
        body.push_back(CH_LBRACK);
        n = pick_length();
        for (int i = 0; i < n; i++) body.push_back(pick_content(CH_RBRACK));
        body.push_back(CH_RBRACK);
        body.push_back(CH_GT);
      end
      default: begin
        body.push_back(CH_SPACE);
        for (int i = 0; i < 6; i++) body.push_back(SYSTEM_KW[i]);
        body.push_back(CH_SPACE);
        body.push_back(CH_QUOTE);
        n = pick_length();
        for (int i = 0; i < n; i++) body.push_back(pick_content(CH_QUOTE));
        body.push_back(CH_QUOTE);
        body.push_back(CH_GT);
      end
    endcase
    at = $urandom_range(0, body.size() - 1);
    damage = $urandom_range(0, 9);
    case (damage)
      // overwrite one byte, often with end of input
      6, 7: body[at] = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
      // cut short, next declaration starts in the middle of this one
      8: while (body.size() > at + 1) void'(body.pop_back());
      // end of input slipped in
      9: body.insert(at, CH_NUL);
      default: ;
    endcase
    foreach (body[i]) add_byte(i == 0, body[i]);
    // stray bytes, mostly ignored by an idle parser
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus, end of run and verdict
  initial begin
    // idle bytes with no start are ignored
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'hFF);
    // end of input and a bad first keyword byte
    add_byte(1'b1, CH_NUL);
    add_byte(1'b1, 8'hFF);
    // restart in the middle of the keyword, then a tab after it
    add_byte(1'b1, "D");
    add_byte(1'b0, "O");
    add_byte(1'b0, "C");
    for (int i = 0; i < 7; i++) add_byte(i == 0, DOCTYPE_KW[i]);
    add_byte(1'b0, 8'h09);
    // shortest valid declaration
    for (int i = 0; i < 7; i++) add_byte(i == 0, DOCTYPE_KW[i]);
    add_byte(1'b0, CH_SPACE);
    add_byte(1'b0, CH_US);
    add_byte(1'b0, CH_GT);
    while (pending_bytes.size() < ITEM_TARGET) add_declaration();

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d bytes, checked %0d results, %0d declarations completed",
             bytes_sent, results_seen, decls_done);
    $display("error codes observed (bit per code): %b", errors_seen[12:0]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // input driver: new item only once the previous one has been taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 &&
          (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        in_valid  <= 1'b1;
        start_req <= it.start;
        in_byte   <= it.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the parser up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && results_seen >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  function automatic void check_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", field, expv, actv);
      mismatch_count++;
    end
  endfunction

  // accepted items feed the decoder, accepted results are checked
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_byte(start_req, in_byte));
        bytes_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (done_res) decls_done++;
        errors_seen[error_code] = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: byte %0d kind %0d done %0d error %0d",
                 out_byte, out_kind, done_res, error_code);
          mismatch_count++;
        end else begin
          parse_result_t want;
          want = expected_results.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_kind", want.kind, out_kind);
          check_field("done_res", want.done, done_res);
          check_field("error_code", want.err, error_code);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
